>>> rtl/ephs_pkg.sv
// Shared types and constants of the exclusion process hop step unit.
`default_nettype none

package ephs_pkg;

    localparam int RATE_W  = 16;
    localparam int PICK_W  = 16;
    localparam int MOVER_W = 4;
    localparam int LAND_W  = 6;
    localparam int SUM_W   = 21;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    // command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_HOP     = 1'b1;

    // configuration register indexes
    localparam logic REG_LEFT_RATE  = 1'b0;
    localparam logic REG_RIGHT_RATE = 1'b1;

    typedef logic [3:0] t_state;

    localparam t_state ST_INIT = 4'd0;
    localparam t_state ST_IDLE = 4'd1;
    localparam t_state ST_MUL  = 4'd2;
    localparam t_state ST_ADD  = 4'd3;
    localparam t_state ST_TGT  = 4'd4;
    localparam t_state ST_SL   = 4'd5;
    localparam t_state ST_SR   = 4'd6;
    localparam t_state ST_RDM  = 4'd7;
    localparam t_state ST_RDP  = 4'd8;
    localparam t_state ST_UPD  = 4'd9;
    localparam t_state ST_WRM  = 4'd10;
    localparam t_state ST_WRP  = 4'd11;
    localparam t_state ST_DONE = 4'd12;

endpackage

`default_nettype wire

>>> rtl/ephs_slot_mem.sv
// Particle table RAM: one write port, one read port with registered read data.
`default_nettype none

module ephs_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/exclusion_process_hop_step_unit.sv
// Exclusion process hop step: one kinetic Monte Carlo hop on a 1-D lattice per transfer.
// Hop: the slot walk tests one slot per cycle and reads one table RAM entry per particle.
// Restart: table rewrite, one entry per cycle.
// One item at a time: the next input transfer can come in the same cycle that the result is raised.
// Reset: synchronous; then a table rewrite runs with the input stalled.
`default_nettype none

module exclusion_process_hop_step_unit
    import ephs_pkg::*;
#(
    parameter int SITES     = 64,
    parameter int PARTICLES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [RATE_W-1:0] i_cfg_data,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [PICK_W-1:0] i_pick,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [MOVER_W-1:0]     o_mover,
    output logic                   o_went_right,
    output logic [LAND_W-1:0]      o_landing_site,
    output logic [SUM_W-1:0]       o_rate_sum,
    output logic                   o_stuck
);

    localparam int KW        = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int PLACE_MAX = (SITES > PARTICLES) ? SITES : PARTICLES;
    localparam int PW        = $clog2(PLACE_MAX);
    localparam int EW        = PW + 2;
    localparam int CW        = $clog2(PARTICLES + 1);
    localparam int PRW       = CW + RATE_W;
    localparam int TW        = PRW + 1;
    localparam int GW        = TW + PICK_W;

    localparam logic [KW-1:0] LAST_K    = KW'(PARTICLES - 1);
    localparam logic [PW-1:0] LAST_SITE = PW'(SITES - 1);
    localparam logic          LAST_FREE = (PARTICLES < SITES);

    // control
    t_state          r_state, n_state;
    logic [KW-1:0]   r_k;
    logic            r_dir;
    logic            r_have_item;
    logic            r_final;
    logic            r_moved;
    logic            r_stuck;
    logic [CW-1:0]   r_cnt_l;
    logic [CW-1:0]   r_cnt_r;
    logic [RATE_W-1:0] r_left_rate;
    logic [RATE_W-1:0] r_right_rate;
    logic            r_out_valid;

    // datapath
    logic [PICK_W-1:0] r_pick;
    logic [PRW-1:0]  r_prod_l;
    logic [PRW-1:0]  r_prod_r;
    logic [TW-1:0]   r_total;
    logic [GW-1:0]   r_target;
    logic [TW-1:0]   r_cum;
    logic [EW-1:0]   r_ek;
    logic [EW-1:0]   r_em;
    logic [EW-1:0]   r_new_m;
    logic [EW-1:0]   r_new_p;
    logic [PW-1:0]   r_pn;
    logic [MOVER_W-1:0] r_o_mover;
    logic            r_o_right;
    logic [LAND_W-1:0] r_o_land;
    logic [SUM_W-1:0]  r_o_sum;
    logic            r_o_stuck;

    // table RAM: entry = {site, left slot enabled, right slot enabled}
    logic            mem_we;
    logic [KW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic            mem_re;
    logic [KW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;

    ephs_slot_mem #(
        .DEPTH (PARTICLES),
        .WIDTH (EW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic            in_xfer;
    logic            out_xfer;
    logic            out_free;
    logic            has_m;
    logic            has_p;
    logic            is_last;
    logic [RATE_W-1:0] slot_rate;
    logic [TW-1:0]   cum_n;
    logic            hit;
    logic [PW-1:0]   p_k;
    logic [PW-1:0]   pn;
    logic [PW:0]     pn_x;
    logic [PW:0]     pn1;
    logic [PW:0]     m_pl1;
    logic [PW:0]     p_pl;
    logic            new_kl;
    logic            new_kr;
    logic            new_mr;
    logic            new_pl;
    logic [CW-1:0]   cnt_l_n;
    logic [CW-1:0]   cnt_r_n;
    logic [KW+MOVER_W-1:0] k_ext;
    logic [PW+LAND_W-1:0]  pn_ext;
    logic [TW+SUM_W-1:0]   tot_ext;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !(r_out_valid && i_out_stall);
    assign has_m    = (r_k != '0);
    assign has_p    = (r_k != LAST_K);
    assign is_last  = (r_k == LAST_K);

    // slot walk: left slot in ST_SL, right slot in ST_SR, both from entry r_k
    always_comb begin
        if (r_state == ST_SL) begin
            slot_rate = mem_rdata[1] ? r_left_rate : '0;
        end else begin
            slot_rate = mem_rdata[0] ? r_right_rate : '0;
        end
    end
    assign cum_n = r_cum + TW'(slot_rate);
    assign hit   = {cum_n, {PICK_W{1'b0}}} > r_target;

    // neighbor refresh; in ST_UPD mem_rdata holds entry k+1
    assign p_k   = r_ek[EW-1:2];
    assign pn    = r_dir ? (p_k + PW'(1)) : (p_k - PW'(1));
    assign pn_x  = {1'b0, pn};
    assign pn1   = pn_x + (PW+1)'(1);
    assign m_pl1 = {1'b0, r_em[EW-1:2]} + (PW+1)'(1);
    assign p_pl  = {1'b0, mem_rdata[EW-1:2]};

    assign new_kl = (pn != '0) && (!has_m || m_pl1 != pn_x);
    assign new_kr = (pn != LAST_SITE) && (!has_p || p_pl != pn1);
    assign new_mr = (m_pl1 != pn_x);
    assign new_pl = (p_pl != pn1);

    assign cnt_l_n = r_cnt_l + CW'(new_kl) - CW'(r_ek[1])
                   + CW'(has_p && new_pl) - CW'(has_p && mem_rdata[1]);
    assign cnt_r_n = r_cnt_r + CW'(new_kr) - CW'(r_ek[0])
                   + CW'(has_m && new_mr) - CW'(has_m && r_em[0]);

    // next state and RAM port control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = r_new_m;
        mem_re    = 1'b0;
        mem_raddr = r_k + KW'(1);
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {PW'(r_k), 1'b0, LAST_FREE && is_last};
                if (is_last) begin
                    n_state = r_have_item ? ST_MUL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_cmd == CMD_HOP) ? ST_MUL : ST_INIT;
                end
            end
            ST_MUL: n_state = ST_ADD;
            ST_ADD: n_state = r_final ? ST_DONE : ST_TGT;
            ST_TGT: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_state   = (r_total == '0) ? ST_DONE : ST_SL;
            end
            ST_SL: begin
                n_state = hit ? ST_RDM : ST_SR;
            end
            ST_SR: begin
                if (hit) begin
                    n_state = ST_RDM;
                end else if (is_last) begin
                    n_state = ST_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_SL;
                end
            end
            ST_RDM: begin
                mem_re    = has_m;
                mem_raddr = r_k - KW'(1);
                n_state   = ST_RDP;
            end
            ST_RDP: begin
                mem_re  = has_p;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                mem_we    = 1'b1;
                mem_wdata = {pn, new_kl, new_kr};
                n_state   = ST_WRM;
            end
            ST_WRM: begin
                mem_we    = has_m;
                mem_waddr = r_k - KW'(1);
                mem_wdata = r_new_m;
                n_state   = ST_WRP;
            end
            ST_WRP: begin
                mem_we    = has_p;
                mem_waddr = r_k + KW'(1);
                mem_wdata = r_new_p;
                n_state   = ST_MUL;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_k          <= '0;
            r_dir        <= 1'b0;
            r_have_item  <= 1'b0;
            r_final      <= 1'b0;
            r_moved      <= 1'b0;
            r_stuck      <= 1'b0;
            r_cnt_l      <= '0;
            r_cnt_r      <= CW'(LAST_FREE);
            r_left_rate  <= RATE_RESET;
            r_right_rate <= RATE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEFT_RATE:  r_left_rate  <= i_cfg_data;
                    REG_RIGHT_RATE: r_right_rate <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_INIT: begin
                    r_k <= is_last ? '0 : (r_k + KW'(1));
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_have_item <= 1'b1;
                        r_moved     <= 1'b0;
                        r_stuck     <= 1'b0;
                        r_k         <= '0;
                        if (i_cmd == CMD_HOP) begin
                            r_final <= 1'b0;
                        end else begin
                            r_final <= 1'b1;
                            r_cnt_l <= '0;
                            r_cnt_r <= CW'(LAST_FREE);
                        end
                    end
                end
                ST_TGT: begin
                    r_k <= '0;
                    if (r_total == '0) begin
                        r_stuck <= 1'b1;
                    end
                end
                ST_SL: begin
                    if (hit) begin
                        r_dir <= 1'b0;
                    end
                end
                ST_SR: begin
                    if (hit) begin
                        r_dir <= 1'b1;
                    end else if (is_last) begin
                        // walk ran out without a pick
                        r_stuck <= 1'b1;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_UPD: begin
                    r_cnt_l <= cnt_l_n;
                    r_cnt_r <= cnt_r_n;
                end
                ST_WRP: begin
                    r_final <= 1'b1;
                    r_moved <= 1'b1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_have_item <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign k_ext   = {{MOVER_W{1'b0}}, r_k};
    assign pn_ext  = {{LAND_W{1'b0}}, r_pn};
    assign tot_ext = {{SUM_W{1'b0}}, r_total};

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pick <= i_pick;
        end
        r_prod_l <= PRW'(r_cnt_l) * PRW'(r_left_rate);
        r_prod_r <= PRW'(r_cnt_r) * PRW'(r_right_rate);
        if (r_state == ST_ADD) begin
            r_total <= TW'(r_prod_l) + TW'(r_prod_r);
        end
        if (r_state == ST_TGT) begin
            r_target <= GW'(r_pick) * GW'(r_total);
            r_cum    <= '0;
        end
        if ((r_state == ST_SL || r_state == ST_SR) && !hit) begin
            r_cum <= cum_n;
        end
        if ((r_state == ST_SL || r_state == ST_SR) && hit) begin
            r_ek <= mem_rdata;
        end
        if (r_state == ST_RDP) begin
            r_em <= mem_rdata;
        end
        if (r_state == ST_UPD) begin
            r_pn    <= pn;
            r_new_m <= {r_em[EW-1:1], new_mr};
            r_new_p <= {mem_rdata[EW-1:2], new_pl, mem_rdata[0]};
        end
        if (r_state == ST_DONE && out_free) begin
            r_o_mover <= r_moved ? k_ext[MOVER_W-1:0] : '0;
            r_o_right <= r_moved && r_dir;
            r_o_land  <= r_moved ? pn_ext[LAND_W-1:0] : '0;
            r_o_sum   <= tot_ext[SUM_W-1:0];
            r_o_stuck <= r_stuck;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_mover        = r_o_mover;
    assign o_went_right   = r_o_right;
    assign o_landing_site = r_o_land;
    assign o_rate_sum     = r_o_sum;
    assign o_stuck        = r_o_stuck;

    // a result only appears from the completion state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside completion");

    // a stuck result carries no move
    a_stuck_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_stuck) |-> (r_o_mover == '0 && !r_o_right && r_o_land == '0))
        else $error("stuck result reports a move");

    // enabled slot counts never exceed the particle count
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_l <= CW'(PARTICLES)) && (r_cnt_r <= CW'(PARTICLES)))
        else $error("enabled slot count out of range");

    // sequencer never reads and writes the table in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("table read and write overlap");

endmodule

`default_nettype wire

>>> tb/ephs_tb_pkg.sv
`timescale 1ns / 100ps
// Lattice tracker class: mirrors the hop step unit and checks its results.
package ephs_tb_pkg;

    import ephs_pkg::*;

    localparam int LAT_SITES = 64;
    localparam int LAT_PARTS = 16;

    typedef struct packed {
        logic [MOVER_W-1:0] mover;
        logic               went_right;
        logic [LAND_W-1:0]  landing;
        logic [SUM_W-1:0]   rate_sum;
        logic               stuck;
    } t_hop_outcome;

    class lattice_tracker;
        logic [RATE_W-1:0] left_w;
        logic [RATE_W-1:0] right_w;
        bit                occ [LAT_SITES];
        int                pos [LAT_PARTS];
        bit                hop_en [2*LAT_PARTS];
        t_hop_outcome      pending_q [$];
        int                mismatches;
        int                hops;
        int                restarts;
        int                stucks;

        function new();
            left_w     = RATE_RESET;
            right_w    = RATE_RESET;
            mismatches = 0;
            hops       = 0;
            restarts   = 0;
            stucks     = 0;
            restart_lattice();
        endfunction

        function void rederive(int k);
            int p;
            p = pos[k];
            hop_en[2*k]   = (p > 0) && !occ[p-1];
            hop_en[2*k+1] = (p + 1 < LAT_SITES) && !occ[p+1];
        endfunction

        function longint slot_weight(int i);
            if (!hop_en[i]) return 0;
            return (i % 2 == 1) ? longint'(right_w) : longint'(left_w);
        endfunction

        function longint enabled_total();
            longint s;
            s = 0;
            for (int i = 0; i < 2*LAT_PARTS; i++) s += slot_weight(i);
            return s;
        endfunction

        // stretched arrangement: particle k at site k
        function void restart_lattice();
            foreach (occ[s]) occ[s] = 1'b0;
            for (int k = 0; k < LAT_PARTS; k++) begin
                pos[k] = k;
                if (k < LAT_SITES) occ[k] = 1'b1;
            end
            for (int k = 0; k < LAT_PARTS; k++) rederive(k);
        endfunction

        function void set_rate(logic idx, logic [RATE_W-1:0] v);
            if (idx == REG_LEFT_RATE) begin
                left_w = v;
            end else begin
                right_w = v;
            end
        endfunction

        // advance the lattice by one command and queue the outcome it must produce
        function void take_command(logic cmd, logic [PICK_W-1:0] pick);
            t_hop_outcome outcome;
            longint       total;
            longint       target;
            longint       cum;
            int           chosen;
            int           k;
            int           p;
            bit           found;
            outcome = '0;
            cum     = 0;
            chosen  = 0;
            found   = 1'b0;
            if (cmd == CMD_RESTART) begin
                restart_lattice();
                total = enabled_total();
                outcome.rate_sum = total[SUM_W-1:0];
                restarts++;
            end else begin
                total  = enabled_total();
                target = longint'(pick) * total;
                for (int i = 0; i < 2*LAT_PARTS && !found; i++) begin
                    cum += slot_weight(i);
                    if ((cum << 16) > target) begin
                        chosen = i;
                        found  = 1'b1;
                    end
                end
                // a zero total never finds a slot: nothing moves
                if (!found) begin
                    outcome.rate_sum = total[SUM_W-1:0];
                    outcome.stuck    = 1'b1;
                    stucks++;
                end else begin
                    k = chosen / 2;
                    p = pos[k];
                    occ[p] = 1'b0;
                    p = (chosen % 2 == 1) ? p + 1 : p - 1;
                    occ[p] = 1'b1;
                    pos[k] = p;
                    rederive(k);
                    if (k > 0) rederive(k - 1);
                    if (k + 1 < LAT_PARTS) rederive(k + 1);
                    total = enabled_total();
                    outcome.mover      = k[MOVER_W-1:0];
                    outcome.went_right = (chosen % 2 == 1);
                    outcome.landing    = p[LAND_W-1:0];
                    outcome.rate_sum   = total[SUM_W-1:0];
                    hops++;
                end
            end
            pending_q.push_back(outcome);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_outcome(t_hop_outcome got);
            t_hop_outcome want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            compare_field("mover", want.mover, got.mover);
            compare_field("went_right", want.went_right, got.went_right);
            compare_field("landing_site", want.landing, got.landing);
            compare_field("rate_sum", want.rate_sum, got.rate_sum);
            compare_field("stuck", want.stuck, got.stuck);
        endfunction
    endclass

endpackage

>>> tb/tb_exclusion_process_hop_step_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the exclusion process hop step unit.
module tb_exclusion_process_hop_step_unit;

    import ephs_pkg::*;
    import ephs_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1150;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_LEFT_RATE;
    logic [RATE_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_cmd = CMD_HOP;
    logic [PICK_W-1:0]  in_pick = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [MOVER_W-1:0] o_mover;
    logic               o_went_right;
    logic [LAND_W-1:0]  o_landing_site;
    logic [SUM_W-1:0]   o_rate_sum;
    logic               o_stuck;

    lattice_tracker tracker = new();
    int             cycles = 0;
    int             items_sent = 0;
    int             settings_used = 0;
    bit             quiet = 1'b0;

    exclusion_process_hop_step_unit #(
        .SITES     (LAT_SITES),
        .PARTICLES (LAT_PARTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (in_cmd),
        .i_pick         (in_pick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_mover        (o_mover),
        .o_went_right   (o_went_right),
        .o_landing_site (o_landing_site),
        .o_rate_sum     (o_rate_sum),
        .o_stuck        (o_stuck)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL exclusion_process_hop_step_unit");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (o_out_valid && !out_stall) begin
            tracker.match_outcome({o_mover, o_went_right, o_landing_site, o_rate_sum, o_stuck});
        end
    end

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            out_stall = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            n = gap_cycles();
            if (n > 0) begin
                @(negedge i_clk);
                out_stall = 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // one input transfer; valid stays high when the next item follows with no gap
    task automatic push_item(logic cmd, logic [PICK_W-1:0] pick);
        int gap;
        gap = gap_cycles();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_cmd   = cmd;
        in_pick  = pick;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_command(cmd, pick);
        items_sent++;
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rates(logic [RATE_W-1:0] lw, logic [RATE_W-1:0] rw);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = REG_LEFT_RATE;
        cfg_data  = lw;
        @(negedge i_clk);
        cfg_index = REG_RIGHT_RATE;
        cfg_data  = rw;
        @(negedge i_clk);
        cfg_we = 1'b0;
        tracker.set_rate(REG_LEFT_RATE, lw);
        tracker.set_rate(REG_RIGHT_RATE, rw);
        settings_used++;
    endtask

    function automatic logic [PICK_W-1:0] random_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return PICK_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        int                sel;
        int                len;
        logic [RATE_W-1:0] lw;
        logic [RATE_W-1:0] rw;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset rates: at first only the last particle can hop, right
        push_item(CMD_HOP, 16'h0000);
        push_item(CMD_HOP, 16'hFFFF);
        push_item(CMD_HOP, 16'h8000);
        push_item(CMD_HOP, 16'h5555);
        push_item(CMD_RESTART, 16'hFFFF);
        push_item(CMD_HOP, 16'hAAAA);

        // both rates zero: stuck lattice, restart reports a zero total
        settle();
        write_rates(16'h0000, 16'h0000);
        push_item(CMD_HOP, 16'h1234);
        push_item(CMD_RESTART, 16'h0000);
        push_item(CMD_HOP, 16'hFFFF);

        settle();
        write_rates(16'hFFFF, 16'hFFFF);
        push_item(CMD_HOP, 16'h0000);
        push_item(CMD_HOP, 16'hFFFF);
        push_item(CMD_HOP, 16'hAAAA);
        push_item(CMD_HOP, 16'h5555);
        push_item(CMD_HOP, 16'h0000);

        // enabled slots of zero weight must never be picked
        settle();
        write_rates(16'h0000, 16'hFFFF);
        push_item(CMD_HOP, 16'h0000);
        push_item(CMD_HOP, 16'hFFFF);
        push_item(CMD_HOP, 16'h8000);

        settle();
        write_rates(16'hFFFF, 16'h0000);
        push_item(CMD_HOP, 16'h0000);
        push_item(CMD_HOP, 16'hFFFF);
        push_item(CMD_HOP, 16'h4000);
        push_item(CMD_RESTART, 16'h0000);

        while (items_sent < ITEM_TARGET) begin
            settle();
            sel = $urandom_range(0, 9);
            len = $urandom_range(60, 120);
            case (sel)
                0: begin
                    lw = '0;
                    rw = '1;
                    len = 30;
                end
                1: begin
                    lw = '1;
                    rw = '0;
                    len = 30;
                end
                2: begin
                    lw = '1;
                    rw = '1;
                end
                3: begin
                    lw = 16'd1;
                    rw = 16'd1;
                end
                4: begin
                    lw = RATE_RESET;
                    rw = RATE_RESET;
                end
                5: begin
                    lw = '0;
                    rw = '0;
                    len = 4;
                end
                default: begin
                    lw = RATE_W'($urandom_range(0, 65535));
                    rw = ($urandom_range(0, 4) == 0) ? RATE_W'($urandom_range(0, 3))
                                                     : RATE_W'($urandom_range(0, 65535));
                end
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            write_rates(lw, rw);
            if ($urandom_range(0, 2) == 0) push_item(CMD_RESTART, random_pick());
            repeat (len) begin
                push_item(($urandom_range(0, 29) == 0) ? CMD_RESTART : CMD_HOP, random_pick());
            end
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Run covered %0d items under %0d rate settings:", items_sent, settings_used);
        $display("  %0d hops, %0d restarts, %0d stuck results, %0d mismatches",
                 tracker.hops, tracker.restarts, tracker.stucks, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_q.size() == 0) begin
            $display("PASS exclusion_process_hop_step_unit");
        end else begin
            $display("FAIL exclusion_process_hop_step_unit");
        end
        $finish;
    end

endmodule
